// ----- src/serial_command_and_table_loader_assert.svh -----
// Assertion macros for the serial command and table loader checker.
`ifndef SERIAL_COMMAND_AND_TABLE_LOADER_ASSERT_SVH
`define SERIAL_COMMAND_AND_TABLE_LOADER_ASSERT_SVH
`define SCTL_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SCTL_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- src/sctl_pkg.sv -----
// Package with payload types, phase codes and constants of the loader.
`timescale 1ns / 1ps
package sctl_pkg;
  localparam int BUFFER_LEN = 18;
  localparam int IDX_W = $clog2(BUFFER_LEN);
  localparam int MAX_ROW_COUNT = 64;
  localparam int MAX_COL_COUNT = 256;
  localparam logic [15:0] SIZE_TIMEOUT_RESET = 16'd20000;
  localparam logic [15:0] ROW_TIMEOUT_RESET = 16'd1000;

  localparam logic [0:0] CFG_SIZE_TIMEOUT = 1'd0;
  localparam logic [0:0] CFG_ROW_TIMEOUT = 1'd1;

  localparam logic [2:0] EV_NONE = 3'd0;
  localparam logic [2:0] EV_RESTART = 3'd1;
  localparam logic [2:0] EV_NEXT = 3'd2;
  localparam logic [2:0] EV_TOGGLE = 3'd3;
  localparam logic [2:0] EV_STOP = 3'd4;

  localparam logic [3:0] MSG_NONE = 4'd0;
  localparam logic [3:0] MSG_STOP_ACK = 4'd1;
  localparam logic [3:0] MSG_TIMEOUT = 4'd2;
  localparam logic [3:0] MSG_ERR_SIZE = 4'd3;
  localparam logic [3:0] MSG_SIZE_ACK = 4'd4;
  localparam logic [3:0] MSG_ERR_TIM = 4'd5;
  localparam logic [3:0] MSG_TIM_ACK = 4'd6;
  localparam logic [3:0] MSG_ERR_DAC = 4'd7;
  localparam logic [3:0] MSG_ALL_DONE = 4'd8;

  typedef enum logic [1:0] {PH_CMD, PH_SIZE, PH_TIM, PH_DAC} phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_code;
    logic [3:0] message_code;
    logic       write_valid;
    logic       write_target;
    logic [5:0] write_row;
    logic [7:0] write_col;
    logic [1:0] write_lane;
    logic [7:0] write_data;
    logic       commit_valid;
    logic [6:0] commit_rows;
    logic [8:0] commit_cols;
  } out_item_t;
endpackage

// ----- src/serial_command_and_table_loader.sv -----
// Top level of the serial command parser and table loader.
//  channel | direction | payload
//  in      | input     | in_item_t (req_type, rx_byte)
//  out     | output    | out_item_t (events, messages, writes, commit)
//  cfg     | input     | cfg_index, cfg_data
// Each transfer updates the state and result registers; one item per cycle is sustained while out_ready holds.
// The result register frees in the same cycle it is taken, so input stalls
// only while a result waits. Reset is synchronous.
`timescale 1ns / 1ps
module serial_command_and_table_loader (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sctl_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sctl_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [0:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import sctl_pkg::*;

  logic [15:0] size_to, row_to;
  logic [7:0]  buffer [BUFFER_LEN];
  logic [7:0]  buffer_next [BUFFER_LEN];
  logic [IDX_W-1:0] cidx, cidx_next;
  logic        stop_pending, stop_pending_next;
  phase_t      phase, phase_next;
  logic [31:0] dims, dims_next;
  logic [9:0]  bcnt, bcnt_next;
  logic [6:0]  rcnt, rcnt_next;
  logic [15:0] elapsed, elapsed_next;
  logic        res_valid;
  out_item_t   res;
  logic        take;

  assign cfg_ready = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;

  function automatic logic has_kw(input logic [7:0] b [BUFFER_LEN],
                                  input logic [55:0] kw, input int len);
    logic found;
    logic ok;
    logic alive;
    found = 1'b0;
    for (int p = 0; p < BUFFER_LEN; p++) begin
      ok = (p + len <= BUFFER_LEN);
      alive = 1'b1;
      for (int k = 0; k < 7; k++) begin
        if (k < len && p + k < BUFFER_LEN) begin
          if (b[p+k] == 8'd0) alive = 1'b0;
          if (b[p+k] != kw[8*(6-k) +: 8]) ok = 1'b0;
        end
      end
      // A zero before p ends the string.
      for (int q = 0; q < BUFFER_LEN; q++) begin
        if (q < p && b[q] == 8'd0) alive = 1'b0;
      end
      if (ok && alive) found = 1'b1;
    end
    return found;
  endfunction

  always_comb begin
    logic [7:0] tmp [BUFFER_LEN];
    logic [IDX_W-1:0] wi;
    logic [IDX_W-1:0] ni;
    logic hit;
    logic [15:0] el;
    logic [15:0] lim;
    logic [15:0] rows, cols;
    logic [10:0] nb;
    logic [6:0]  nr;
    buffer_next = buffer;
    cidx_next = cidx;
    stop_pending_next = stop_pending;
    phase_next = phase;
    dims_next = dims;
    bcnt_next = bcnt;
    rcnt_next = rcnt;
    elapsed_next = elapsed;
    res_valid = 1'b0;
    res = '0;
    tmp = buffer;
    wi = cidx;
    ni = '0;
    hit = 1'b0;
    el = '0;
    lim = '0;
    rows = dims[15:0];
    cols = dims[31:16];
    nb = '0;
    nr = '0;
    if (phase == PH_CMD) begin
      if (in_data.req_type) begin
        if (stop_pending) begin
          stop_pending_next = 1'b0;
          phase_next = PH_SIZE;
          dims_next = '0;
          bcnt_next = '0;
          rcnt_next = '0;
          elapsed_next = '0;
          res_valid = 1'b1;
          res.event_code = EV_STOP;
          res.message_code = MSG_STOP_ACK;
        end
      end else begin
        tmp[wi] = in_data.rx_byte;
        ni = (wi == IDX_W'(BUFFER_LEN - 1)) ? '0 : wi + 1'b1;
        tmp[ni] = 8'd0;
        buffer_next = tmp;
        cidx_next = ni;
        hit = 1'b1;
        if (has_kw(tmp, "restart", 7)) begin
          res_valid = 1'b1;
          res.event_code = EV_RESTART;
        end else if (has_kw(tmp, {"start", 16'd0}, 5)) begin
          stop_pending_next = 1'b0;
        end else if (has_kw(tmp, {"stop", 24'd0}, 4)) begin
          stop_pending_next = 1'b1;
        end else if (has_kw(tmp, {"next", 24'd0}, 4)) begin
          res_valid = 1'b1;
          res.event_code = EV_NEXT;
        end else if (has_kw(tmp, {"switch", 8'd0}, 6)) begin
          res_valid = 1'b1;
          res.event_code = EV_TOGGLE;
        end else begin
          hit = 1'b0;
        end
        if (hit) begin
          for (int i = 0; i < BUFFER_LEN; i++) buffer_next[i] = 8'd0;
          cidx_next = '0;
        end
      end
    end else if (in_data.req_type) begin
      lim = (phase == PH_SIZE) ? size_to : row_to;
      el = (elapsed != 16'hFFFF) ? elapsed + 1'b1 : elapsed;
      elapsed_next = el;
      if (el >= lim) begin
        res_valid = 1'b1;
        unique case (phase)
          PH_SIZE: res.message_code = MSG_TIMEOUT;
          PH_TIM:  res.message_code = MSG_ERR_TIM;
          default: res.message_code = MSG_ERR_DAC;
        endcase
        for (int i = 0; i < BUFFER_LEN; i++) buffer_next[i] = 8'd0;
        cidx_next = '0;
        stop_pending_next = 1'b0;
        phase_next = PH_CMD;
        dims_next = '0;
        bcnt_next = '0;
        rcnt_next = '0;
        elapsed_next = '0;
      end
    end else if (phase == PH_SIZE) begin
      dims_next = dims | (32'(in_data.rx_byte) << {bcnt[1:0], 3'b000});
      bcnt_next = bcnt + 1'b1;
      rows = dims_next[15:0];
      cols = dims_next[31:16];
      if (bcnt_next >= 10'd4) begin
        res_valid = 1'b1;
        if (rows == 16'd0 || rows > 16'(MAX_ROW_COUNT) ||
            cols == 16'd0 || cols > 16'(MAX_COL_COUNT)) begin
          res.message_code = MSG_ERR_SIZE;
          for (int i = 0; i < BUFFER_LEN; i++) buffer_next[i] = 8'd0;
          cidx_next = '0;
          stop_pending_next = 1'b0;
          phase_next = PH_CMD;
          dims_next = '0;
          bcnt_next = '0;
          rcnt_next = '0;
          elapsed_next = '0;
        end else begin
          res.message_code = MSG_SIZE_ACK;
          phase_next = PH_TIM;
          bcnt_next = '0;
          rcnt_next = '0;
          elapsed_next = '0;
        end
      end
    end else begin
      res_valid = 1'b1;
      res.write_valid = 1'b1;
      res.write_target = (phase == PH_DAC);
      res.write_row = rcnt[5:0];
      res.write_col = bcnt[9:2];
      res.write_lane = bcnt[1:0];
      res.write_data = in_data.rx_byte;
      nb = {1'b0, bcnt} + 11'd1;
      bcnt_next = nb[9:0];
      if (nb >= {cols[8:0], 2'b00}) begin
        bcnt_next = '0;
        nr = rcnt + 1'b1;
        rcnt_next = nr;
        elapsed_next = '0;
        if (nr >= rows[6:0]) begin
          if (phase == PH_TIM) begin
            phase_next = PH_DAC;
            rcnt_next = '0;
            res.message_code = MSG_TIM_ACK;
          end else begin
            res.event_code = EV_RESTART;
            res.message_code = MSG_ALL_DONE;
            res.commit_valid = 1'b1;
            res.commit_rows = rows[6:0];
            res.commit_cols = cols[8:0];
            for (int i = 0; i < BUFFER_LEN; i++) buffer_next[i] = 8'd0;
            cidx_next = '0;
            stop_pending_next = 1'b0;
            phase_next = PH_CMD;
            dims_next = '0;
            bcnt_next = '0;
            rcnt_next = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_to <= SIZE_TIMEOUT_RESET;
      row_to <= ROW_TIMEOUT_RESET;
      for (int i = 0; i < BUFFER_LEN; i++) buffer[i] <= 8'd0;
      cidx <= '0;
      stop_pending <= 1'b0;
      phase <= PH_CMD;
      dims <= '0;
      bcnt <= '0;
      rcnt <= '0;
      elapsed <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_SIZE_TIMEOUT) size_to <= cfg_data;
        if (cfg_index == CFG_ROW_TIMEOUT) row_to <= cfg_data;
      end
      if (take) begin
        buffer <= buffer_next;
        cidx <= cidx_next;
        stop_pending <= stop_pending_next;
        phase <= phase_next;
        dims <= dims_next;
        bcnt <= bcnt_next;
        rcnt <= rcnt_next;
        elapsed <= elapsed_next;
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_data <= res;
  end
endmodule

// ----- src/sctl_checker.sv -----
// Port checker for the loader, bound to the top level.
`timescale 1ns / 1ps
`include "serial_command_and_table_loader_assert.svh"
module sctl_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input sctl_pkg::out_item_t out_data
);
  import sctl_pkg::*;
  `SCTL_ASSERT_IMPL(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `SCTL_ASSERT_IMPL(a_ready, clk, rst, (!out_valid || out_ready) |-> in_ready, "input blocked with free result register")
  `SCTL_ASSERT_IMPL(a_commit, clk, rst, out_valid && out_data.commit_valid |-> out_data.write_valid && out_data.message_code == MSG_ALL_DONE, "commit without final write")
  `SCTL_ASSERT_NORST(a_reset, clk, rst |=> !out_valid, "result valid after reset")
endmodule

bind serial_command_and_table_loader sctl_checker u_sctl_checker (.*);
